>>> rtl/core/mpls_pkg.sv
// ============================================================================
// mpls_pkg: shared types and constants of the multi-pattern line search
// Holds the channel payload types, command and register codes, and the
// structures that carry control between the pattern bank and the line scanner.
// ============================================================================
package mpls_pkg;

    localparam int MAX_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int MAX_LINE        = 8192;

    localparam int CMD_W      = 3;
    localparam int IDX_W      = $clog2(MAX_PATTERNS);
    localparam int POS_W      = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W      = $clog2(MAX_PATTERN_LEN + 1);
    localparam int LINE_W     = $clog2(MAX_LINE);
    localparam int CNT_W      = 16;
    localparam int PCNT_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_PAT_BYTE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PAT_LEN    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN_FILE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DATA_BYTE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END_FILE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CASE_INSENSITIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT    = 1'b1;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] pattern_index;
        logic [POS_W-1:0] char_position;
        t_byte            data_byte;
        logic [LEN_W-1:0] pattern_length;
    } t_in_item;

    typedef struct packed {
        logic                    satisfied;
        logic [MAX_PATTERNS-1:0] found_mask;
        logic [CNT_W-1:0]        files_searched;
        logic [CNT_W-1:0]        files_matched;
    } t_out_item;

    typedef struct packed {
        logic             byte_we;
        logic             len_we;
        logic [IDX_W-1:0] index;
        logic [POS_W-1:0] position;
        t_byte            data;
        logic [LEN_W-1:0] length;
    } t_pat_wr;

    typedef struct packed {
        logic [MAX_PATTERNS-1:0][MAX_PATTERN_LEN-1:0][7:0] bytes;
        logic [MAX_PATTERNS-1:0][LEN_W-1:0]                eff_len;
    } t_pat_view;

    typedef struct packed {
        logic                    byte_valid;
        logic                    clear_file;
        logic                    case_fold;
        logic [MAX_PATTERNS-1:0] active;
        t_byte                   data;
    } t_scan_ctl;

endpackage

>>> rtl/core/multi_pattern_line_search_top.sv
// ============================================================================
// multi_pattern_line_search_top: multi-pattern line search, top level
// Loads search patterns, scans a file byte stream line by line and reports
// per file whether every pattern in use occurred within a single line.
// ============================================================================
// Usage: items arrive on the input channel (i_in_valid, o_in_ready,
// i_in_data). Pattern byte and pattern length items load the pattern bank,
// begin file clears the per-file state, data bytes are scanned and an end
// file item produces one transaction on the output channel (o_out_valid,
// i_out_ready, o_out_data); no other item produces a result.
// Every accepted item is held in an input register and then processed by
// a single comparator stage that checks all patterns at once, so one item
// per cycle is sustained unless a stalled receiver holds an end file item.
// The result of an end file item is registered in the output register
// as the item leaves the input register.
// The user must write the configuration port (i_cfg_we, i_cfg_index,
// i_cfg_data) while no transaction is in flight; this is not enforced.
// Reset clears the line and file state, the file counters and both channel
// valids, and restores the default configuration; pattern contents stay
// undefined until loaded. When the receiver stalls, the result is held in
// the output register and the block keeps accepting items until a second
// end file item reaches the input register.
// ============================================================================
module multi_pattern_line_search_top
    import mpls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_item                r_in;
    logic                    r_in_valid;
    t_out_item               r_out;
    logic                    r_out_valid;
    logic                    r_case_fold;
    logic [PCNT_W-1:0]       r_pat_count;
    logic [CNT_W-1:0]        r_searched;
    logic [CNT_W-1:0]        r_matched;

    logic                    end_item;
    logic                    advance;
    logic                    end_go;
    logic [PCNT_W-1:0]       n_use;
    logic [MAX_PATTERNS-1:0] active;
    logic [MAX_PATTERNS-1:0] found;
    logic                    sat;
    t_pat_wr                 pat_wr;
    t_pat_view               pat_view;
    t_scan_ctl               scan_ctl;

    assign end_item   = (r_in.cmd == CMD_END_FILE);
    assign advance    = r_in_valid && (!end_item || !r_out_valid || i_out_ready);
    assign end_go     = advance && end_item;
    assign o_in_ready = !r_in_valid || advance;

    assign n_use = (r_pat_count == '0) ? PCNT_W'(1) :
                   (r_pat_count > PCNT_W'(MAX_PATTERNS)) ? PCNT_W'(MAX_PATTERNS) :
                   r_pat_count;

    always_comb begin
        for (int p = 0; p < MAX_PATTERNS; p++) begin
            active[p] = (PCNT_W'(p) < n_use);
        end
    end

    assign sat = ((found & active) == active);

    always_comb begin
        pat_wr.byte_we  = advance && (r_in.cmd == CMD_PAT_BYTE);
        pat_wr.len_we   = advance && (r_in.cmd == CMD_PAT_LEN);
        pat_wr.index    = r_in.pattern_index;
        pat_wr.position = r_in.char_position;
        pat_wr.data     = r_in.data_byte;
        pat_wr.length   = r_in.pattern_length;

        scan_ctl.byte_valid = advance && (r_in.cmd == CMD_DATA_BYTE);
        scan_ctl.clear_file = advance && ((r_in.cmd == CMD_BEGIN_FILE) || end_item);
        scan_ctl.case_fold  = r_case_fold;
        scan_ctl.active     = active;
        scan_ctl.data       = r_in.data_byte;
    end

    mpls_pattern_bank u_bank (
        .i_clk  (i_clk),
        .i_wr   (pat_wr),
        .o_view (pat_view)
    );

    mpls_line_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_pat   (pat_view),
        .o_found (found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_fold <= 1'b0;
            r_pat_count <= PCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CASE_INSENSITIVE: r_case_fold <= i_cfg_data[0];
                CFG_PATTERN_COUNT:    r_pat_count <= i_cfg_data[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_searched  <= '0;
            r_matched   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (end_go) begin
                r_out_valid <= 1'b1;
                r_searched  <= r_searched + 1'b1;
                r_matched   <= r_matched + CNT_W'(sat);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (end_go) begin
            r_out.satisfied      <= sat;
            r_out.found_mask     <= found;
            r_out.files_searched <= r_searched + 1'b1;
            r_out.files_matched  <= r_matched + CNT_W'(sat);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid set right after reset.");
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_go |=> o_out_valid)
        else $error("End file transaction did not produce a result.");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && end_item && o_out_valid && !i_out_ready))
        else $error("Input stalled without a blocked result.");
`endif

endmodule

>>> rtl/core/mpls_pattern_bank.sv
// ============================================================================
// mpls_pattern_bank: pattern byte and length storage
// Holds every pattern byte in its own register so that all comparators see
// the whole set at once, and derives each pattern's effective length.
// ============================================================================
module mpls_pattern_bank
    import mpls_pkg::*;
(
    input  logic      i_clk,
    input  t_pat_wr   i_wr,
    output t_pat_view o_view
);

    t_byte               r_pat [MAX_PATTERNS][MAX_PATTERN_LEN];
    logic [LEN_W-1:0]    r_len [MAX_PATTERNS];

    logic [LEN_W-1:0]           len_sat   [MAX_PATTERNS];
    logic [MAX_PATTERN_LEN-1:0] zero_hit  [MAX_PATTERNS];
    logic [MAX_PATTERN_LEN-1:0] first_hit [MAX_PATTERNS];
    logic [LEN_W-1:0]           hit_pos   [MAX_PATTERNS];

    always_ff @(posedge i_clk) begin
        if (i_wr.byte_we) begin
            r_pat[i_wr.index][i_wr.position] <= i_wr.data;
        end
        if (i_wr.len_we) begin
            r_len[i_wr.index] <= i_wr.length;
        end
    end

    // A pattern ends at its length or at its first zero byte.
    always_comb begin
        for (int p = 0; p < MAX_PATTERNS; p++) begin
            len_sat[p] = (r_len[p] > LEN_W'(MAX_PATTERN_LEN)) ?
                         LEN_W'(MAX_PATTERN_LEN) : r_len[p];
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                zero_hit[p][i] = (r_pat[p][i] == '0) && (LEN_W'(i) < len_sat[p]);
            end
            first_hit[p] = zero_hit[p] & (~zero_hit[p] + MAX_PATTERN_LEN'(1));
            hit_pos[p]   = '0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                if (first_hit[p][i]) begin
                    hit_pos[p] = hit_pos[p] | LEN_W'(i);
                end
            end
            o_view.eff_len[p] = (zero_hit[p] == '0) ? len_sat[p] : hit_pos[p];
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                o_view.bytes[p][i] = r_pat[p][i];
            end
        end
    end

endmodule

>>> rtl/core/mpls_line_scan.sv
// ============================================================================
// mpls_line_scan: line history and per-pattern comparators
// Keeps the visible tail of the current line and compares it against every
// pattern in use on each data byte, collecting the found flags of the file.
// ============================================================================
module mpls_line_scan
    import mpls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_scan_ctl               i_ctl,
    input  t_pat_view               i_pat,
    output logic [MAX_PATTERNS-1:0] o_found
);

    localparam t_byte CHAR_UPPER_A = 8'h41;
    localparam t_byte CHAR_UPPER_Z = 8'h5A;
    localparam t_byte CHAR_NEWLINE = 8'h0A;
    localparam t_byte FOLD_OFFSET  = 8'h20;
    localparam int    HIST_W       = MAX_PATTERN_LEN * 8;

    t_byte                   r_hist [MAX_PATTERN_LEN];
    t_byte                   hist_byte [MAX_PATTERN_LEN];
    logic [LINE_W-1:0]       r_line_fill, n_line_fill;
    logic [LEN_W-1:0]        r_vis, n_vis;
    logic                    r_zero_seen, n_zero_seen;
    logic [MAX_PATTERNS-1:0] r_found, n_found;

    logic                    zs_byte;
    logic [LEN_W-1:0]        vis_byte;
    logic [HIST_W-1:0]       hist_vec;
    logic [LEN_W-1:0]        shift   [MAX_PATTERNS];
    logic [HIST_W-1:0]       aligned [MAX_PATTERNS];
    logic [MAX_PATTERN_LEN-1:0] cmp_ok [MAX_PATTERNS];
    logic [MAX_PATTERNS-1:0] hit;
    logic                    line_end;

    function automatic t_byte fold_byte(input logic en, input t_byte b);
        if (en && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
            return b + FOLD_OFFSET;
        end
        return b;
    endfunction

    // History as it stands once the incoming byte is taken.
    always_comb begin
        zs_byte  = r_zero_seen | (i_ctl.data == '0);
        vis_byte = r_vis;
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            hist_byte[k] = r_hist[k];
        end
        if (!zs_byte) begin
            for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) begin
                hist_byte[k] = r_hist[k + 1];
            end
            hist_byte[MAX_PATTERN_LEN - 1] = i_ctl.data;
            if (r_vis < LEN_W'(MAX_PATTERN_LEN)) begin
                vis_byte = r_vis + 1'b1;
            end
        end
        for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            hist_vec[8*k +: 8] = fold_byte(i_ctl.case_fold, hist_byte[k]);
        end
    end

    // The newest bytes are shifted down so that they line up with pattern position zero.
    always_comb begin
        for (int p = 0; p < MAX_PATTERNS; p++) begin
            shift[p]   = LEN_W'(MAX_PATTERN_LEN) - i_pat.eff_len[p];
            aligned[p] = hist_vec >> {shift[p], 3'b000};
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                cmp_ok[p][i] = (LEN_W'(i) >= i_pat.eff_len[p]) ||
                               (aligned[p][8*i +: 8] ==
                                fold_byte(i_ctl.case_fold, i_pat.bytes[p][i]));
            end
            hit[p] = i_ctl.active[p] &&
                     ((i_pat.eff_len[p] == '0) ||
                      (!zs_byte && (i_pat.eff_len[p] <= vis_byte) && (&cmp_ok[p])));
        end
    end

    assign line_end = (i_ctl.data == CHAR_NEWLINE) ||
                      (r_line_fill >= LINE_W'(MAX_LINE - 2));

    always_comb begin
        n_found     = r_found;
        n_vis       = r_vis;
        n_line_fill = r_line_fill;
        n_zero_seen = r_zero_seen;
        if (i_ctl.clear_file) begin
            n_found     = '0;
            n_vis       = '0;
            n_line_fill = '0;
            n_zero_seen = 1'b0;
        end else if (i_ctl.byte_valid) begin
            n_found = r_found | hit;
            if (line_end) begin
                n_vis       = '0;
                n_line_fill = '0;
                n_zero_seen = 1'b0;
            end else begin
                n_vis       = vis_byte;
                n_line_fill = r_line_fill + 1'b1;
                n_zero_seen = zs_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= '0;
            r_vis       <= '0;
            r_line_fill <= '0;
            r_zero_seen <= 1'b0;
        end else begin
            r_found     <= n_found;
            r_vis       <= n_vis;
            r_line_fill <= n_line_fill;
            r_zero_seen <= n_zero_seen;
        end
    end

    // Bytes older than the visible count are never compared, so the history needs no clear.
    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_valid) begin
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                r_hist[k] <= hist_byte[k];
            end
        end
    end

    assign o_found = r_found;

`ifndef SYNTHESIS
    a_line_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_fill < LINE_W'(MAX_LINE - 1))
        else $error("Line fill passed the line length limit.");
    a_vis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vis <= LEN_W'(MAX_PATTERN_LEN))
        else $error("Visible fill passed the history depth.");
    a_vis_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LINE_W'(r_vis) <= r_line_fill)
        else $error("Visible fill exceeds the line fill.");
    a_file_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear_file |=> (r_found == '0))
        else $error("Found flags survived a file boundary.");
`endif

endmodule

>>> dv/multi_pattern_line_search_top_tb.sv
// ============================================================================
// multi_pattern_line_search_top_tb: self-checking bench for the line search
// Loads pattern banks, streams files through the input channel and mirrors
// every accepted transaction in a local model of the search state. Each end
// file report is checked field by field against the mirrored prediction,
// with random sender bursts and receiver stalls.
// ============================================================================
module multi_pattern_line_search_top_tb;
    import mpls_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1550;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Mirror of the search state.
    logic [7:0]              pat_mem     [MAX_PATTERNS][MAX_PATTERN_LEN];
    logic [LEN_W-1:0]        pat_len_mem [MAX_PATTERNS];
    logic [7:0]              line_hist   [MAX_PATTERN_LEN];
    int                      line_bytes;
    int                      line_visible;
    bit                      line_zero;
    logic [MAX_PATTERNS-1:0] file_found;
    logic [CNT_W-1:0]        files_done = '0;
    logic [CNT_W-1:0]        files_hit  = '0;
    bit                      fold_en    = 1'b0;
    logic [PCNT_W-1:0]       count_reg  = PCNT_W'(1);

    t_out_item pending_reports[$];

    int errors     = 0;
    int items_sent = 0;
    int burst_left = 0;
    bit steady     = 1'b0;
    int rcv_mode   = 0;
    int rcv_tick   = 0;

    multi_pattern_line_search_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    always @(negedge clk) begin
        rcv_tick <= rcv_tick + 1;
        case (rcv_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ((rcv_tick % 11) < 6);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic [7:0] fold_char(logic [7:0] c);
        if (fold_en && c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic int patterns_live();
        if (count_reg == 0) begin
            return 1;
        end
        if (count_reg > MAX_PATTERNS) begin
            return MAX_PATTERNS;
        end
        return int'(count_reg);
    endfunction

    function automatic int effective_len(int p);
        int len;
        len = int'(pat_len_mem[p]);
        if (len > MAX_PATTERN_LEN) begin
            len = MAX_PATTERN_LEN;
        end
        for (int i = 0; i < len; i++) begin
            if (pat_mem[p][i] == 8'd0) begin
                return i;
            end
        end
        return len;
    endfunction

    function automatic bit tail_hit(int p, int len);
        if (len > line_visible) begin
            return 1'b0;
        end
        for (int i = 0; i < len; i++) begin
            if (fold_char(line_hist[MAX_PATTERN_LEN - len + i]) != fold_char(pat_mem[p][i])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            line_hist[i] = 8'd0;
        end
        line_bytes   = 0;
        line_visible = 0;
        line_zero    = 1'b0;
    endfunction

    function automatic void clear_file();
        clear_line();
        file_found = '0;
    endfunction

    function automatic void take_data(logic [7:0] b);
        int len;
        if (b == 8'd0) begin
            line_zero = 1'b1;
        end
        if (!line_zero) begin
            for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) begin
                line_hist[i] = line_hist[i + 1];
            end
            line_hist[MAX_PATTERN_LEN - 1] = b;
            if (line_visible < MAX_PATTERN_LEN) begin
                line_visible++;
            end
        end
        for (int p = 0; p < patterns_live(); p++) begin
            if (!file_found[p]) begin
                len = effective_len(p);
                if (len == 0 || (!line_zero && tail_hit(p, len))) begin
                    file_found[p] = 1'b1;
                end
            end
        end
        line_bytes++;
        if (b == 8'h0A || line_bytes >= MAX_LINE - 1) begin
            clear_line();
        end
    endfunction

    function automatic void apply_item(t_in_item it);
        t_out_item               rep;
        logic [MAX_PATTERNS-1:0] need;
        int                      n;
        case (it.cmd)
            CMD_PAT_BYTE: pat_mem[it.pattern_index][it.char_position] = it.data_byte;
            CMD_PAT_LEN: pat_len_mem[it.pattern_index] = it.pattern_length;
            CMD_BEGIN_FILE: clear_file();
            CMD_DATA_BYTE: take_data(it.data_byte);
            CMD_END_FILE: begin
                n = patterns_live();
                need = (n >= MAX_PATTERNS) ? '1 : MAX_PATTERNS'((1 << n) - 1);
                rep.satisfied = ((file_found & need) == need);
                files_done = files_done + 1'b1;
                if (rep.satisfied) begin
                    files_hit = files_hit + 1'b1;
                end
                rep.found_mask     = file_found;
                rep.files_searched = files_done;
                rep.files_matched  = files_hit;
                pending_reports.push_back(rep);
                clear_file();
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(string field, int unsigned want, int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual %h", $time, out_data);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (out_data.satisfied !== want.satisfied) begin
                    note_mismatch("satisfied", want.satisfied, out_data.satisfied);
                end
                if (out_data.found_mask !== want.found_mask) begin
                    note_mismatch("found_mask", want.found_mask, out_data.found_mask);
                end
                if (out_data.files_searched !== want.files_searched) begin
                    note_mismatch("files_searched", want.files_searched, out_data.files_searched);
                end
                if (out_data.files_matched !== want.files_matched) begin
                    note_mismatch("files_matched", want.files_matched, out_data.files_matched);
                end
            end
        end
    end

    task automatic push_item(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        apply_item(it);
        if (it.cmd <= CMD_END_FILE) begin
            items_sent++;
        end
    endtask

    function automatic t_in_item rand_item(logic [CMD_W-1:0] cmd);
        t_in_item it;
        it.cmd            = cmd;
        it.pattern_index  = IDX_W'($urandom);
        it.char_position  = POS_W'($urandom);
        it.data_byte      = 8'($urandom);
        it.pattern_length = LEN_W'($urandom);
        return it;
    endfunction

    task automatic send_cmd(logic [CMD_W-1:0] cmd);
        push_item(rand_item(cmd));
    endtask

    task automatic send_data(logic [7:0] b);
        t_in_item it;
        it = rand_item(CMD_DATA_BYTE);
        it.data_byte = b;
        push_item(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_data(s[i]);
        end
    endtask

    task automatic load_byte(int p, int pos, logic [7:0] b);
        t_in_item it;
        it = rand_item(CMD_PAT_BYTE);
        it.pattern_index = IDX_W'(p);
        it.char_position = POS_W'(pos);
        it.data_byte     = b;
        push_item(it);
    endtask

    task automatic load_len(int p, int len);
        t_in_item it;
        it = rand_item(CMD_PAT_LEN);
        it.pattern_index  = IDX_W'(p);
        it.pattern_length = LEN_W'(len);
        push_item(it);
    endtask

    task automatic load_text(int p, string s, int len);
        for (int i = 0; i < s.len(); i++) begin
            load_byte(p, i, s[i]);
        end
        load_len(p, len);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CASE_INSENSITIVE) begin
            fold_en = val[0];
        end else begin
            count_reg = val;
        end
    endtask

    function automatic logic [7:0] rand_text_char();
        string letters;
        letters = "abAB";
        case ($urandom_range(0, 9))
            7: return 8'h0A;
            8: return 8'($urandom);
            9: return ($urandom_range(0, 3) == 0) ? 8'd0 : "c";
            default: return letters[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic test_pattern_bank_fill();
        rcv_mode = 1;
        for (int p = 0; p < MAX_PATTERNS; p++) begin
            for (int pos = 0; pos < MAX_PATTERN_LEN; pos++) begin
                load_byte(p, pos, 8'($urandom));
            end
            load_len(p, $urandom_range(0, 63));
        end
        send_cmd(CMD_END_FILE);
        settle();
    endtask

    task automatic test_directed_cases();
        rcv_mode = 2;
        write_cfg(CFG_CASE_INSENSITIVE, 4'b1110);
        write_cfg(CFG_PATTERN_COUNT, 4'd4);
        load_text(0, "Ab", 2);
        load_len(1, 0);
        load_byte(2, 0, "x");
        load_byte(2, 1, "y");
        load_byte(2, 2, 8'd0);
        load_byte(2, 3, "z");
        load_len(2, 4);
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            load_byte(3, i, 8'(33 + i));
        end
        load_len(3, 63);

        send_cmd(CMD_BEGIN_FILE);
        send_text("xaB Ab\n");
        send_data(8'hFF);
        send_data(8'h80);
        send_text("x");
        send_data(8'd0);
        send_text("y\n");
        send_cmd(3'd5);
        send_cmd(3'd6);
        send_cmd(3'd7);
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            send_data(8'(33 + i));
        end
        send_cmd(CMD_END_FILE);
        // Data with no begin file item still counts toward the next report.
        send_text("xy");
        send_cmd(CMD_END_FILE);
        settle();

        rcv_mode = 3;
        write_cfg(CFG_CASE_INSENSITIVE, 4'b0001);
        send_cmd(CMD_BEGIN_FILE);
        send_text("AB XY");
        send_cmd(CMD_END_FILE);
        settle();

        write_cfg(CFG_PATTERN_COUNT, 4'd0);
        send_cmd(CMD_BEGIN_FILE);
        send_data(8'd0);
        send_text("ab");
        send_cmd(CMD_END_FILE);
        settle();

        write_cfg(CFG_PATTERN_COUNT, 4'd15);
        send_cmd(CMD_BEGIN_FILE);
        send_text("ab");
        send_cmd(CMD_END_FILE);
        settle();
    endtask

    task automatic test_line_length_limit();
        rcv_mode = 0;
        write_cfg(CFG_CASE_INSENSITIVE, 4'd0);
        write_cfg(CFG_PATTERN_COUNT, 4'd1);
        load_text(0, "ab", 2);
        steady = 1'b1;
        // The forced line break falls between the two pattern bytes.
        send_cmd(CMD_BEGIN_FILE);
        repeat (MAX_LINE - 2) send_data("x");
        send_text("ab");
        send_cmd(CMD_END_FILE);
        // Here the pattern ends on the last byte of the line.
        send_cmd(CMD_BEGIN_FILE);
        repeat (MAX_LINE - 3) send_data("x");
        send_text("ab");
        send_cmd(CMD_END_FILE);
        steady = 1'b0;
        settle();
    endtask

    task automatic test_random_files();
        int          start;
        int          p;
        int          len;
        logic [7:0]  b;
        logic [3:0]  cnt;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_cfg(CFG_CASE_INSENSITIVE, CFG_DATA_W'($urandom));
                case ($urandom_range(0, 5))
                    0: cnt = 4'd0;
                    1: cnt = 4'd1;
                    2: cnt = 4'd8;
                    3: cnt = 4'd15;
                    default: cnt = 4'($urandom_range(1, MAX_PATTERNS));
                endcase
                write_cfg(CFG_PATTERN_COUNT, cnt);
            end
            rcv_mode = $urandom_range(0, 3);
            steady   = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                p = $urandom_range(0, MAX_PATTERNS - 1);
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(0, 63);
                    for (int i = 0; i < len && i < MAX_PATTERN_LEN; i++) begin
                        load_byte(p, i, 8'($urandom));
                    end
                end else begin
                    len = $urandom_range(0, 4);
                    for (int i = 0; i < len; i++) begin
                        load_byte(p, i, rand_text_char());
                    end
                end
                load_len(p, len);
            end
            if ($urandom_range(0, 9) != 0) begin
                send_cmd(CMD_BEGIN_FILE);
            end
            repeat ($urandom_range(0, 40)) begin
                case ($urandom_range(0, 19))
                    0: begin
                        p = $urandom_range(0, patterns_live() - 1);
                        len = effective_len(p);
                        for (int i = 0; i < len; i++) begin
                            b = pat_mem[p][i];
                            if (((b | 8'h20) >= "a") && ((b | 8'h20) <= "z")
                                    && $urandom_range(0, 1) == 1) begin
                                b = b ^ 8'h20;
                            end
                            send_data(b);
                        end
                    end
                    1: begin
                        case ($urandom_range(0, 2))
                            0: send_cmd(3'($urandom_range(5, 7)));
                            1: load_byte($urandom_range(0, MAX_PATTERNS - 1),
                                         $urandom_range(0, MAX_PATTERN_LEN - 1), rand_text_char());
                            default: load_len($urandom_range(0, MAX_PATTERNS - 1),
                                              $urandom_range(0, 6));
                        endcase
                    end
                    default: send_data(rand_text_char());
                endcase
            end
            send_cmd(CMD_END_FILE);
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_file();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_pattern_bank_fill();
        test_directed_cases();
        test_line_length_limit();
        test_random_files();

        settle();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
